@@ rtl/core/pds_pkg.sv @@
package pds_pkg;

    localparam int M_COUNT  = 128;
    localparam int N_COUNT  = 16;
    localparam int OD_COUNT = 3;

    localparam int DATA_W = 32;
    localparam int M_W    = (M_COUNT > 1) ? $clog2(M_COUNT) : 1;
    localparam int N_W    = (N_COUNT > 1) ? $clog2(N_COUNT) : 1;
    localparam int OD_W   = (OD_COUNT > 1) ? $clog2(OD_COUNT) : 1;
    // divisor n+1 runs up to N_COUNT
    localparam int D_W    = (N_COUNT > 1) ? $clog2(N_COUNT + 1) : 1;
    // xtal * (m+1) at full width
    localparam int Q_W    = DATA_W + $clog2(M_COUNT + 1);
    // target << od at full width
    localparam int VCO_W  = DATA_W + OD_COUNT - 1;

    localparam int MULT_W   = 7;
    localparam int DIVN_W   = 4;
    localparam int OD_OUT_W = 2;

    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] VCO_LOW_HZ  = 32'd500_000_000;
    localparam logic [DATA_W-1:0] VCO_HIGH_HZ = 32'd1_500_000_000;
    localparam logic [DATA_W-1:0] REF_LOW_HZ  = 32'd1_000_000;
    localparam logic [DATA_W-1:0] REF_HIGH_HZ = 32'd50_000_000;
    localparam logic [DATA_W-1:0] NO_ERROR_HZ = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] XTAL_RESET  = 32'd12_000_000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OD_CHECK,
        ST_N_START,
        ST_DIV_WAIT,
        ST_M_STEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic od_inc;
        logic n_clear;
        logic n_inc;
        logic div_start;
        logic m_init;
        logic m_step;
        logic best_upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic vco_ok;
        logic od_last;
        logic n_last;
        logic div_done;
        logic ref_low;
        logic ref_high;
        logic got_above;
        logic better;
        logic exact;
        logic m_last;
    } t_sts;

endpackage

@@ rtl/core/pds_divider.sv @@
module pds_divider
    import pds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [D_W-1:0]    i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quo,
    output logic [D_W-1:0]    o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_quo;
    logic [D_W-1:0]    r_rem;

    logic [D_W:0]      part;
    logic              fits;
    logic [D_W:0]      diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        part = {r_rem, r_quo[DATA_W-1]};
        fits = (part >= {1'b0, i_divisor});
        diff = part - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DATA_W-2:0], fits};
            r_rem <= fits ? diff[D_W-1:0] : part[D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/pds_datapath.sv @@
module pds_datapath
    import pds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [DATA_W-1:0]   i_target_hz,
    input  logic [DATA_W-1:0]   i_crystal_hz,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [MULT_W-1:0]   o_mult_m,
    output logic [DIVN_W-1:0]   o_div_n,
    output logic [OD_OUT_W-1:0] o_out_od,
    output logic                o_found,
    output logic [DATA_W-1:0]   o_error_hz
);

    logic [DATA_W-1:0]   r_target;
    logic [OD_W-1:0]     r_od;
    logic [N_W-1:0]      r_n;
    logic [M_W-1:0]      r_m;
    logic [Q_W-1:0]      r_q;
    logic [D_W-1:0]      r_r;
    logic [DATA_W-1:0]   r_qx;
    logic [D_W-1:0]      r_rx;

    logic [DATA_W-1:0]   r_best_err;
    logic [M_W-1:0]      r_best_m;
    logic [N_W-1:0]      r_best_n;
    logic [OD_W-1:0]     r_best_od;
    logic                r_hit;

    logic [MULT_W-1:0]   r_out_m;
    logic [DIVN_W-1:0]   r_out_n;
    logic [OD_OUT_W-1:0] r_out_od;
    logic                r_out_found;
    logic [DATA_W-1:0]   r_out_err;

    logic [D_W-1:0]      divisor;
    logic                div_done;
    logic [DATA_W-1:0]   div_quo;
    logic [D_W-1:0]      div_rem;

    logic [VCO_W-1:0]    vco;
    logic [Q_W-1:0]      got;
    logic [DATA_W-1:0]   err;
    logic [D_W:0]        rsum;
    logic                carry;
    logic [Q_W-1:0]      n_q;
    logic [D_W-1:0]      n_r;

    assign divisor = D_W'(r_n) + D_W'(1);

    pds_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_crystal_hz),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // (xtal*(m+1))/(n+1) kept as quotient and remainder, one xtal added per m
    always_comb begin
        vco   = VCO_W'(r_target) << r_od;
        got   = r_q >> r_od;
        err   = r_target - got[DATA_W-1:0];
        rsum  = {1'b0, r_r} + {1'b0, r_rx};
        carry = (rsum >= {1'b0, divisor});
        n_r   = carry ? D_W'(rsum - {1'b0, divisor}) : rsum[D_W-1:0];
        n_q   = r_q + Q_W'(r_qx) + Q_W'(carry);
    end

    always_comb begin
        o_sts.vco_ok    = (vco >= VCO_W'(VCO_LOW_HZ)) && (vco <= VCO_W'(VCO_HIGH_HZ));
        o_sts.od_last   = (r_od == OD_W'(OD_COUNT - 1));
        o_sts.n_last    = (r_n == N_W'(N_COUNT - 1));
        o_sts.div_done  = div_done;
        o_sts.ref_low   = (div_quo < REF_LOW_HZ);
        o_sts.ref_high  = (div_quo > REF_HIGH_HZ);
        o_sts.got_above = (got > Q_W'(r_target));
        o_sts.better    = (err < r_best_err);
        o_sts.exact     = (err == '0);
        o_sts.m_last    = (r_m == M_W'(M_COUNT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_target_hz;
            r_od     <= '0;
        end else if (i_cmd.od_inc) begin
            r_od <= r_od + OD_W'(1);
        end

        if (i_cmd.n_clear) begin
            r_n <= '0;
        end else if (i_cmd.n_inc) begin
            r_n <= r_n + N_W'(1);
        end

        if (i_cmd.m_init) begin
            r_m  <= '0;
            r_q  <= Q_W'(div_quo);
            r_r  <= div_rem;
            r_qx <= div_quo;
            r_rx <= div_rem;
        end else if (i_cmd.m_step) begin
            r_m <= r_m + M_W'(1);
            r_q <= n_q;
            r_r <= n_r;
        end

        if (i_cmd.load) begin
            r_best_err <= NO_ERROR_HZ;
            r_best_m   <= '0;
            r_best_n   <= '0;
            r_best_od  <= '0;
            r_hit      <= 1'b0;
        end else if (i_cmd.best_upd) begin
            r_best_err <= err;
            r_best_m   <= r_m;
            r_best_n   <= r_n;
            r_best_od  <= r_od;
            r_hit      <= 1'b1;
        end

        if (i_cmd.out_load) begin
            r_out_m     <= MULT_W'(r_best_m);
            r_out_n     <= DIVN_W'(r_best_n);
            r_out_od    <= OD_OUT_W'(r_best_od);
            r_out_found <= r_hit;
            r_out_err   <= r_best_err;
        end
    end

    assign o_mult_m   = r_out_m;
    assign o_div_n    = r_out_n;
    assign o_out_od   = r_out_od;
    assign o_found    = r_out_found;
    assign o_error_hz = r_out_err;

endmodule

@@ rtl/core/pds_ctrl.sv @@
module pds_ctrl
    import pds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall,
    output logic o_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_OD_CHECK;
                end
            end
            ST_OD_CHECK: begin
                if (i_sts.vco_ok) begin
                    o_cmd.n_clear = 1'b1;
                    n_state       = ST_N_START;
                end else if (i_sts.od_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.od_inc = 1'b1;
                end
            end
            ST_N_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    if (i_sts.ref_low) begin
                        // divided reference too low: no larger n can help
                        if (i_sts.od_last) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.od_inc = 1'b1;
                            n_state      = ST_OD_CHECK;
                        end
                    end else if (i_sts.ref_high) begin
                        if (i_sts.n_last) begin
                            if (i_sts.od_last) begin
                                n_state = ST_FINISH;
                            end else begin
                                o_cmd.od_inc = 1'b1;
                                n_state      = ST_OD_CHECK;
                            end
                        end else begin
                            o_cmd.n_inc = 1'b1;
                            n_state     = ST_N_START;
                        end
                    end else begin
                        o_cmd.m_init = 1'b1;
                        n_state      = ST_M_STEP;
                    end
                end
            end
            ST_M_STEP: begin
                if (!i_sts.got_above) begin
                    o_cmd.best_upd = i_sts.better;
                end
                if (!i_sts.got_above && i_sts.better && i_sts.exact) begin
                    n_state = ST_FINISH;
                end else if (i_sts.got_above || i_sts.m_last) begin
                    if (i_sts.n_last) begin
                        if (i_sts.od_last) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.od_inc = 1'b1;
                            n_state      = ST_OD_CHECK;
                        end
                    end else begin
                        o_cmd.n_inc = 1'b1;
                        n_state     = ST_N_START;
                    end
                end else begin
                    o_cmd.m_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ rtl/core/pll_divider_search_core.sv @@
// PLL divider search: one request carries a target output frequency in hertz;
// one result gives multiplier m-1, input divider n-1, output divider exponent,
// a found flag and the error (target minus achieved, all ones if nothing fits).
// The crystal frequency sits in an APB register at byte address 0, 12 MHz after
// reset; write it only while no request is in flight.
// Input channel: i_valid / o_stall, a request is taken when i_valid is high and
// o_stall is low. o_stall stays high from the cycle after a request is taken
// until its result has moved into the output register.
// Output channel: o_valid / i_stall, the result holds while i_stall is high.
// The output register frees the search engine, so the next request is taken
// while a result still waits downstream.
// Search time: each output divider is examined; for each input divider tried
// the engine starts a serial division of the crystal frequency, then steps
// through the multipliers; last the result is loaded. The serial divider and
// the one-multiplier-per-cycle loop set the search time.
// Synchronous active-low reset empties the output register and returns the
// engine to idle.
module pll_divider_search_core
    import pds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  logic [DATA_W-1:0]   i_target_hz,

    output logic                o_valid,
    input  logic                i_stall,
    output logic [MULT_W-1:0]   o_mult_m,
    output logic [DIVN_W-1:0]   o_div_n,
    output logic [OD_OUT_W-1:0] o_out_od,
    output logic                o_found,
    output logic [DATA_W-1:0]   o_error_hz,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [DATA_W-1:0] r_crystal_hz;
    logic              reg_wr;
    logic              reg_sel;
    t_cmd              cmd;
    t_sts              sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? r_crystal_hz : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal_hz <= XTAL_RESET;
        end else if (reg_wr) begin
            r_crystal_hz <= pwdata;
        end
    end

    pds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    pds_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target_hz  (i_target_hz),
        .i_crystal_hz (r_crystal_hz),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_mult_m     (o_mult_m),
        .o_div_n      (o_div_n),
        .o_out_od     (o_out_od),
        .o_found      (o_found),
        .o_error_hz   (o_error_hz)
    );

endmodule

@@ rtl/core/pds_checker.sv @@
module pds_props
    import pds_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [MULT_W-1:0]   o_mult_m,
    input logic [DIVN_W-1:0]   o_div_n,
    input logic [OD_OUT_W-1:0] o_out_od,
    input logic                o_found,
    input logic [DATA_W-1:0]   o_error_hz
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mult_m) && $stable(o_div_n)
            && $stable(o_out_od) && $stable(o_found) && $stable(o_error_hz)))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("engine took no notice of a request");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_error_hz == NO_ERROR_HZ && o_mult_m == '0
            && o_div_n == '0 && o_out_od == '0))
        else $error("empty result carries a setting");

    a_found_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_error_hz != NO_ERROR_HZ))
        else $error("found result with no error value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind pll_divider_search_core pds_props u_pds_props (.*);

@@ tb/pds_tb_pkg.sv @@
package pds_tb_pkg;

    // apb byte address of the crystal frequency register
    localparam logic [2:0] REG_CRYSTAL_ADDR = 3'd0;

endpackage

@@ tb/pds_checker.sv @@
module pds_checker
    import pds_pkg::*;
    import pds_tb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic [DATA_W-1:0]   i_target_hz,

    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  logic [MULT_W-1:0]   i_mult_m,
    input  logic [DIVN_W-1:0]   i_div_n,
    input  logic [OD_OUT_W-1:0] i_out_od,
    input  logic                i_found,
    input  logic [DATA_W-1:0]   i_error_hz,

    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,

    output int                  o_mismatches,
    output int                  o_pending
);

    typedef struct packed {
        logic [MULT_W-1:0]   mult_m;
        logic [DIVN_W-1:0]   div_n;
        logic [OD_OUT_W-1:0] out_od;
        logic                found;
        logic [DATA_W-1:0]   error_hz;
    } t_setting;

    t_setting          pending_settings[$];
    logic [DATA_W-1:0] crystal_hz;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // best pll setting not above the target, od then n then m ascending
    function automatic t_setting search_pll_setting(input logic [DATA_W-1:0] target,
                                                    input logic [DATA_W-1:0] xtal);
        t_setting    best;
        logic [63:0] xtal_w;
        logic [63:0] target_w;
        logic [63:0] best_err;
        logic [63:0] vco_hz;
        logic [63:0] ref_hz;
        logic [63:0] got_hz;
        logic [63:0] err_hz;
        bit          hit;
        bit          exact;
        best     = '0;
        xtal_w   = {32'd0, xtal};
        target_w = {32'd0, target};
        best_err = {32'd0, NO_ERROR_HZ};
        hit      = 1'b0;
        exact    = 1'b0;
        for (int od = 0; od < OD_COUNT && !exact; od++) begin
            vco_hz = target_w << od;
            if (vco_hz < VCO_LOW_HZ || vco_hz > VCO_HIGH_HZ)
                continue;
            for (int n = 0; n < N_COUNT && !exact; n++) begin
                ref_hz = xtal_w / (n + 1);
                if (ref_hz < REF_LOW_HZ)
                    break;
                if (ref_hz > REF_HIGH_HZ)
                    continue;
                for (int m = 0; m < M_COUNT; m++) begin
                    got_hz = ((xtal_w * (m + 1)) / (n + 1)) >> od;
                    if (got_hz > target_w)
                        break;
                    err_hz = target_w - got_hz;
                    if (err_hz < best_err) begin
                        best_err    = err_hz;
                        best.mult_m = m[MULT_W-1:0];
                        best.div_n  = n[DIVN_W-1:0];
                        best.out_od = od[OD_OUT_W-1:0];
                        hit         = 1'b1;
                        if (err_hz == 0) begin
                            exact = 1'b1;
                            break;
                        end
                    end
                end
            end
        end
        best.found    = hit;
        best.error_hz = hit ? best_err[DATA_W-1:0] : NO_ERROR_HZ;
        return best;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_setting want;
        if (!i_rst_n) begin
            crystal_hz = XTAL_RESET;
            pending_settings.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_CRYSTAL_ADDR)
                crystal_hz = i_pwdata;
            if (i_res_valid && !i_res_stall) begin
                if (pending_settings.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got m %0d n %0d od %0d found %0d err %0d",
                             $time, i_mult_m, i_div_n, i_out_od, i_found, i_error_hz);
                    o_mismatches++;
                end else begin
                    want = pending_settings.pop_front();
                    compare_field("mult_m", want.mult_m, i_mult_m);
                    compare_field("div_n", want.div_n, i_div_n);
                    compare_field("out_od", want.out_od, i_out_od);
                    compare_field("found", want.found, i_found);
                    compare_field("error_hz", want.error_hz, i_error_hz);
                end
            end
            if (i_req_valid && !i_req_stall)
                pending_settings.push_back(search_pll_setting(i_target_hz, crystal_hz));
        end
        o_pending = pending_settings.size();
    end

endmodule

@@ tb/tb.sv @@
module tb;
    import pds_pkg::*;
    import pds_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 100_000;
    localparam int SETTLE_CYCLES   = 8_000;
    localparam int NUM_CRYSTALS    = 10;
    localparam int ITEMS_PER_XTAL  = 8;
    localparam int NUM_DIRECTED    = 21;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [DATA_W-1:0]   i_target_hz = '0;
    logic                i_stall     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;

    logic                o_stall;
    logic                o_valid;
    logic [MULT_W-1:0]   o_mult_m;
    logic [DIVN_W-1:0]   o_div_n;
    logic [OD_OUT_W-1:0] o_out_od;
    logic                o_found;
    logic [DATA_W-1:0]   o_error_hz;
    logic [31:0]         prdata;
    logic                pready;

    int                  mismatches;
    int                  pending;
    int                  send_gap_pct   = 19;
    int                  recv_stall_pct = 72;
    int                  quiet_cycles   = 0;
    logic [DATA_W-1:0]   xtal_now       = XTAL_RESET;

    logic [DATA_W-1:0] directed_targets [NUM_DIRECTED] = '{
        32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd12_000_000,
        32'd124_999_999, 32'd125_000_000, 32'd249_999_999, 32'd250_000_000,
        32'd333_333_333, 32'd375_000_000, 32'd375_000_001, 32'd499_999_999,
        32'd500_000_000, 32'd600_000_001, 32'd750_000_000, 32'd750_000_001,
        32'd1_000_000_007, 32'd1_200_000_000, 32'd1_499_999_999,
        32'd1_500_000_000, 32'd1_500_000_001
    };

    // zero, too high for every divider, too low at once, window edges, ordinary
    logic [DATA_W-1:0] crystal_plan [NUM_CRYSTALS] = '{
        32'd0, 32'hFFFF_FFFF, 32'd999_999, 32'd1_000_000, 32'd50_000_000,
        32'd50_000_001, 32'd27_000_000, 32'd16_000_000, 32'd0, 32'd12_000_000
    };

    logic [DATA_W-1:0] window_marks [6] = '{
        32'd125_000_000, 32'd250_000_000, 32'd375_000_000,
        32'd500_000_000, 32'd750_000_000, 32'd1_500_000_000
    };

    pll_divider_search_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_target_hz (i_target_hz),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_mult_m    (o_mult_m),
        .o_div_n     (o_div_n),
        .o_out_od    (o_out_od),
        .o_found     (o_found),
        .o_error_hz  (o_error_hz),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pds_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_target_hz  (i_target_hz),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_mult_m     (o_mult_m),
        .i_div_n      (o_div_n),
        .i_out_od     (o_out_od),
        .i_found      (o_found),
        .i_error_hz   (o_error_hz),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_target(input logic [DATA_W-1:0] target);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_target_hz <= target;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_crystal(input logic [31:0] hz);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CRYSTAL_ADDR;
        pwdata  <= hz;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        xtal_now = hz;
    endtask

    // mix of full-range noise, in-window targets, exact hits, near hits, window edges and tiny targets
    function automatic logic [DATA_W-1:0] pick_target(input logic [DATA_W-1:0] xtal);
        logic [63:0] hz;
        int          m;
        int          n;
        int          od;
        m  = $urandom_range(M_COUNT - 1);
        n  = $urandom_range(N_COUNT - 1);
        od = $urandom_range(OD_COUNT - 1);
        hz = (({32'd0, xtal} * (m + 1)) / (n + 1)) >> od;
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2, 3, 4: return $urandom_range(1_500_000_000, 125_000_000);
            5, 6:    return hz[DATA_W-1:0];
            7:       return window_marks[$urandom_range(5)] + $urandom_range(2) - 1;
            8:       return hz[DATA_W-1:0] + $urandom_range(3);
            default: return $urandom_range(1000);
        endcase
    endfunction

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_targets[i])
            send_target(directed_targets[i]);

        for (int c = 0; c < NUM_CRYSTALS; c++) begin
            if (c == 3) begin
                send_gap_pct   = 72;
                recv_stall_pct = 19;
            end else if (c == 7) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            wait_results_drained();
            if (c == 8)
                write_crystal($urandom_range(60_000_000, 1_000_000));
            else
                write_crystal(crystal_plan[c]);
            for (int k = 0; k < ITEMS_PER_XTAL; k++) begin
                send_target(pick_target(xtal_now));
                if ($urandom_range(15) == 0)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ pll_divider_search_core.f @@
rtl/core/pds_pkg.sv
rtl/core/pds_divider.sv
rtl/core/pds_datapath.sv
rtl/core/pds_ctrl.sv
rtl/core/pll_divider_search_core.sv
rtl/core/pds_checker.sv
tb/pds_tb_pkg.sv
tb/pds_checker.sv
tb/tb.sv
